>>> hdl/mgpeh_pkg.sv
// ----------------------------------------------------------------------------
// mgpeh_pkg
// Shared widths, the layer entry type and the saturating total adder used by
// the maximum-gain exact-hop path engine.
// ----------------------------------------------------------------------------
`default_nettype none

package mgpeh_pkg;

	localparam int TOTAL_W   = 24;
	localparam int REACH_W   = 8;
	localparam int NGAIN_W   = 16;
	localparam int NINDEX_W  = 8;
	localparam int CFG_W     = 7;
	localparam int IN_DATA_W = 32;
	localparam int OUT_DATA_W = 24;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
	localparam logic [CFG_W-1:0]   EXTRA_STOPS_RESET = CFG_W'(1);

	typedef struct packed {
		logic               valid;
		logic [TOTAL_W-1:0] total;
	} layer_entry_t;

	function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
			input logic [31:0] b);
		logic [32:0] sum;
		sum = 33'(a) + 33'(b);
		return (sum > 33'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];
	endfunction

endpackage

`default_nettype wire

>>> hdl/mgpeh_node_mem.sv
// ----------------------------------------------------------------------------
// mgpeh_node_mem
// Node store: one gain memory and one reach memory, each with one write port
// and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mgpeh_node_mem #(
	parameter int DEPTH  = 256,
	parameter int IDX_W  = 8,
	parameter int GAIN_W = 16
) (
	input  wire logic                           clk,
	input  wire logic                           we,
	input  wire logic [IDX_W-1:0]               waddr,
	input  wire logic [GAIN_W-1:0]              wgain,
	input  wire logic [mgpeh_pkg::REACH_W-1:0]  wreach,
	input  wire logic                           gain_re,
	input  wire logic [IDX_W-1:0]               gain_raddr,
	output logic      [GAIN_W-1:0]              gain_rdata,
	input  wire logic                           reach_re,
	input  wire logic [IDX_W-1:0]               reach_raddr,
	output logic      [mgpeh_pkg::REACH_W-1:0]  reach_rdata
);
	import mgpeh_pkg::*;

	logic [GAIN_W-1:0]  gain_mem  [DEPTH];
	logic [REACH_W-1:0] reach_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			gain_mem[waddr]  <= wgain;
			reach_mem[waddr] <= wreach;
		end
		if (gain_re) begin
			gain_rdata <= gain_mem[gain_raddr];
		end
		if (reach_re) begin
			reach_rdata <= reach_mem[reach_raddr];
		end
	end

endmodule

`default_nettype wire

>>> hdl/mgpeh_layer_mem.sv
// ----------------------------------------------------------------------------
// mgpeh_layer_mem
// Layer store: two banks of best totals with valid marks, one write port and
// one registered read port. The bank is the top address bit.
// ----------------------------------------------------------------------------
`default_nettype none

module mgpeh_layer_mem #(
	parameter int ADDR_W = 9
) (
	input  wire logic                          clk,
	input  wire logic                          we,
	input  wire logic [ADDR_W-1:0]             waddr,
	input  wire mgpeh_pkg::layer_entry_t       wdata,
	input  wire logic                          re,
	input  wire logic [ADDR_W-1:0]             raddr,
	output mgpeh_pkg::layer_entry_t            rdata
);
	import mgpeh_pkg::*;

	layer_entry_t mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> hdl/max_gain_path_exact_hops.sv
// ----------------------------------------------------------------------------
// max_gain_path_exact_hops
// Greatest total gain over forward paths with an exact number of hops.
// ----------------------------------------------------------------------------
// Nodes arrive on the s_ request channel, one per cycle while the block is
// loading: s_tdata carries the index, gain and reach, and s_tlast marks the
// final node. The final node starts a layered search; the result leaves on
// the m_ channel with the best total in m_tdata and the found flag in m_tuser.
// The hop count is to be written by the user on the cfg channel only while
// the block is idle; the block itself does not enforce this, and the cfg
// channel is always ready. The per-hop cost is set by the single read port of
// the layer memory, which is visited once for every node pair i < z. Node
// loading accepts one node per cycle.
// The output register holds a finished result until it is taken; loading of
// the next node set goes on meanwhile, and a new result waits in the engine
// until the output register is free.
// Reset empties the node set, clears the output, and sets the hop count to 1.
// No clearing pass is needed: every layer entry used has been written first.
// ----------------------------------------------------------------------------
`default_nettype none

module max_gain_path_exact_hops #(
	parameter int MAX_NODES = 256,
	parameter int MAX_HOPS  = 64,
	parameter int GAIN_BITS = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [mgpeh_pkg::CFG_W-1:0]       cfg_data,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// node_index [7:0], node_gain [23:8], node_reach [31:24]
	input  wire logic [mgpeh_pkg::IN_DATA_W-1:0]   s_tdata,
	input  wire logic                              s_tlast,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// best_total [23:0]
	output logic      [mgpeh_pkg::OUT_DATA_W-1:0]  m_tdata,
	// path_found [0]
	output logic                                   m_tuser
);
	import mgpeh_pkg::*;

	localparam int IDX_W  = $clog2(MAX_NODES);
	localparam int CNT_W  = $clog2(MAX_NODES + 1);
	localparam int HOP_W  = $clog2(MAX_HOPS + 1);
	localparam int LA_W   = IDX_W + 1;
	localparam int SUM_W  = ((IDX_W > REACH_W) ? IDX_W : REACH_W) + 1;

	typedef enum logic [3:0] {
		S_LOAD, S_START, S_ZSTART, S_SWEEP, S_DRAIN, S_WRITE, S_FINRD, S_FINAL, S_OUT
	} state_t;

	state_t                state_q;
	logic [CFG_W-1:0]      extra_stops_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [IDX_W-1:0]      last_idx_q;
	logic [GAIN_BITS-1:0]  gain0_q;
	logic [HOP_W-1:0]      hop_q;
	logic [IDX_W-1:0]      z_q;
	logic [IDX_W-1:0]      i_q;
	logic                  bank_q;
	logic                  first_q;
	logic                  v_s1;
	logic [IDX_W-1:0]      i_s1;
	logic                  acc_v_q;
	logic [TOTAL_W-1:0]    acc_q;
	logic                  res_found_q;
	logic [TOTAL_W-1:0]    res_total_q;

	logic [NGAIN_W-1:0]    in_gain;
	logic [REACH_W-1:0]    in_reach;
	logic [31:0]           in_gain32;
	logic [GAIN_BITS-1:0]  gain_in;
	logic                  in_acc;
	logic [IDX_W-1:0]      slot;
	logic [CNT_W-1:0]      cnt_next;
	logic [HOP_W-1:0]      hops_eff;
	logic [TOTAL_W-1:0]    gain0_sat;

	logic [GAIN_BITS-1:0]  gain_rdata;
	logic [REACH_W-1:0]    reach_rdata;
	logic                  layer_re;
	logic [LA_W-1:0]       layer_raddr;
	layer_entry_t          layer_rdata;
	logic                  layer_we;
	layer_entry_t          layer_wdata;
	layer_entry_t          prev_e;
	logic                  elig;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == S_LOAD);
	assign in_acc    = s_tvalid && s_tready;

	assign in_gain   = s_tdata[NINDEX_W +: NGAIN_W];
	assign in_reach  = s_tdata[NINDEX_W + NGAIN_W +: REACH_W];
	assign in_gain32 = 32'(in_gain);
	assign gain_in   = in_gain32[GAIN_BITS-1:0];

	assign slot      = (cnt_q < CNT_W'(MAX_NODES)) ? cnt_q[IDX_W-1:0]
	                                               : IDX_W'(MAX_NODES - 1);
	assign cnt_next  = (cnt_q < CNT_W'(MAX_NODES)) ? cnt_q + CNT_W'(1) : cnt_q;
	assign hops_eff  = (32'(extra_stops_q) > 32'(MAX_HOPS)) ? HOP_W'(MAX_HOPS)
	                                                        : HOP_W'(extra_stops_q);
	assign gain0_sat = sat_add('0, 32'(gain0_q));

	assign layer_re    = (state_q == S_SWEEP) || (state_q == S_FINRD);
	assign layer_raddr = (state_q == S_SWEEP) ? {bank_q, i_q} : {bank_q, last_idx_q};
	assign layer_we    = (state_q == S_WRITE);

	always_comb begin
		layer_wdata = '0;
		if (acc_v_q) begin
			layer_wdata.valid = 1'b1;
			layer_wdata.total = sat_add(acc_q, 32'(gain_rdata));
		end
	end

	// In the first hop the previous layer holds only the start node.
	always_comb begin
		prev_e = layer_rdata;
		if (first_q) begin
			prev_e = '0;
			if (i_s1 == '0) begin
				prev_e.valid = 1'b1;
				prev_e.total = gain0_sat;
			end
		end
	end

	assign elig = v_s1 && prev_e.valid
	              && ((SUM_W'(i_s1) + SUM_W'(reach_rdata)) >= SUM_W'(z_q));

	mgpeh_node_mem #(
		.DEPTH (MAX_NODES),
		.IDX_W (IDX_W),
		.GAIN_W(GAIN_BITS)
	) u_node_mem (
		.clk        (clk),
		.we         (in_acc),
		.waddr      (slot),
		.wgain      (gain_in),
		.wreach     (in_reach),
		.gain_re    (state_q == S_ZSTART),
		.gain_raddr (z_q),
		.gain_rdata (gain_rdata),
		.reach_re   (state_q == S_SWEEP),
		.reach_raddr(i_q),
		.reach_rdata(reach_rdata)
	);

	mgpeh_layer_mem #(
		.ADDR_W(LA_W)
	) u_layer_mem (
		.clk  (clk),
		.we   (layer_we),
		.waddr({~bank_q, z_q}),
		.wdata(layer_wdata),
		.re   (layer_re),
		.raddr(layer_raddr),
		.rdata(layer_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_LOAD;
			extra_stops_q <= EXTRA_STOPS_RESET;
			cnt_q         <= '0;
			last_idx_q    <= '0;
			gain0_q       <= '0;
			hop_q         <= '0;
			z_q           <= '0;
			i_q           <= '0;
			bank_q        <= 1'b0;
			first_q       <= 1'b1;
			v_s1          <= 1'b0;
			i_s1          <= '0;
			acc_v_q       <= 1'b0;
			acc_q         <= '0;
			res_found_q   <= 1'b0;
			res_total_q   <= '0;
			m_tvalid      <= 1'b0;
			m_tdata       <= '0;
			m_tuser       <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				extra_stops_q <= cfg_data;
			end
			if (m_tvalid && m_tready && (state_q != S_OUT)) begin
				m_tvalid <= 1'b0;
			end

			v_s1 <= (state_q == S_SWEEP);
			i_s1 <= i_q;
			if (state_q == S_ZSTART) begin
				acc_v_q <= 1'b0;
			end else if (elig && (!acc_v_q || (prev_e.total > acc_q))) begin
				acc_v_q <= 1'b1;
				acc_q   <= prev_e.total;
			end

			unique case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						if (cnt_q == '0) begin
							gain0_q <= gain_in;
						end
						if (s_tlast) begin
							last_idx_q <= IDX_W'(cnt_next - CNT_W'(1));
							cnt_q      <= '0;
							state_q    <= S_START;
						end else begin
							cnt_q <= cnt_next;
						end
					end
				end
				S_START: begin
					if (hops_eff == '0) begin
						res_found_q <= (last_idx_q == '0);
						res_total_q <= (last_idx_q == '0) ? gain0_sat : '0;
						state_q     <= S_OUT;
					end else begin
						hop_q   <= '0;
						first_q <= 1'b1;
						z_q     <= '0;
						state_q <= S_ZSTART;
					end
				end
				S_ZSTART: begin
					i_q <= '0;
					if (z_q == '0) begin
						state_q <= S_WRITE;
					end else begin
						state_q <= S_SWEEP;
					end
				end
				S_SWEEP: begin
					if (i_q == z_q - IDX_W'(1)) begin
						state_q <= S_DRAIN;
					end else begin
						i_q <= i_q + IDX_W'(1);
					end
				end
				S_DRAIN: begin
					state_q <= S_WRITE;
				end
				S_WRITE: begin
					if (z_q == last_idx_q) begin
						bank_q  <= ~bank_q;
						first_q <= 1'b0;
						z_q     <= '0;
						if ((hop_q + HOP_W'(1)) == hops_eff) begin
							state_q <= S_FINRD;
						end else begin
							hop_q   <= hop_q + HOP_W'(1);
							state_q <= S_ZSTART;
						end
					end else begin
						z_q     <= z_q + IDX_W'(1);
						state_q <= S_ZSTART;
					end
				end
				S_FINRD: begin
					state_q <= S_FINAL;
				end
				S_FINAL: begin
					res_found_q <= layer_rdata.valid;
					res_total_q <= layer_rdata.valid ? layer_rdata.total : '0;
					state_q     <= S_OUT;
				end
				S_OUT: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						m_tdata  <= res_total_q;
						m_tuser  <= res_found_q;
						state_q  <= S_LOAD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
